@@ src/ezr_pkg.sv @@
// Shared types and constants of the z-x-z Euler vector rotation block.
`default_nettype none

package ezr_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int ANGLE_WIDTH = 16;
  localparam int TRIG_WIDTH  = 18;
  localparam int ENTRY_WIDTH = 20;
  localparam int A48_WIDTH   = 52;
  localparam int PROD_WIDTH  = ENTRY_WIDTH + COORD_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + 2;

  // Pipeline depths: input register, sine/cosine unit, matrix and product unit.
  localparam int SC_LAT  = 16;
  localparam int ROT_LAT = 8;
  localparam int LAT     = 1 + SC_LAT + ROT_LAT;

  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  // Divisors of the nested Taylor series, innermost first.
  localparam int SIN_DIV [4] = '{42, 20, 6, 1};
  localparam int COS_DIV [4] = '{56, 30, 12, 2};

  typedef struct packed {
    logic                          op;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;
    logic        [ANGLE_WIDTH-1:0] angle_first;
    logic        [ANGLE_WIDTH-1:0] angle_second;
    logic        [ANGLE_WIDTH-1:0] angle_third;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
  } result_t;

  typedef struct packed {
    logic signed [TRIG_WIDTH-1:0] sn;
    logic signed [TRIG_WIDTH-1:0] cs;
  } trig_t;

endpackage

`default_nettype wire

@@ src/euler_zxz_vector_rotation_top.sv @@
// Top level of the z-x-z Euler vector rotation pipeline.
//
// An item is a vector in signed Q7.16 and three Euler angles (phi, theta, psi)
// in fractions of a turn; op selects the forward or the inverse rotation.
// The item is accepted at a rising edge with start high and busy low. busy
// is always low: the pipeline takes one item in every cycle.
// The result appears on result with done high for exactly one cycle;
// items leave in the order they entered.
// The pipeline is one input register, sixteen stages of the sine and
// cosine units (one product or reciprocal step of the series per stage) and
// eight stages of matrix build, matrix-vector product, rounding and saturation.
// The receiver cannot hold results off, so nothing in the pipeline ever waits.
// Reset clears the valid bits, so no done strobe follows reset until new
// items are accepted; the data registers are not reset.
`default_nettype none

module euler_zxz_vector_rotation_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire ezr_pkg::cmd_t    cmd,
  output logic                  done,
  output ezr_pkg::result_t      result
);

  localparam int CW  = ezr_pkg::COORD_WIDTH;
  localparam int AW  = ezr_pkg::ANGLE_WIDTH;
  localparam int LAT = ezr_pkg::LAT;
  localparam int VD  = ezr_pkg::SC_LAT;

  logic                 accept;
  logic [LAT-1:0]       valid;
  logic [AW-1:0]        ph;
  logic [AW-1:0]        th;
  logic [AW-1:0]        ps;
  logic signed [CW-1:0] vx [0:VD];
  logic signed [CW-1:0] vy [0:VD];
  logic signed [CW-1:0] vz [0:VD];

  ezr_pkg::trig_t trig_ph;
  ezr_pkg::trig_t trig_th;
  ezr_pkg::trig_t trig_ps;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign done   = valid[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LAT-2:0], accept};
    end
  end

  // The inverse uses the reversed angle order, each negated modulo a turn.
  always_ff @(posedge clk) begin
    if (cmd.op) begin
      ph <= AW'(-cmd.angle_third);
      th <= AW'(-cmd.angle_second);
      ps <= AW'(-cmd.angle_first);
    end else begin
      ph <= cmd.angle_first;
      th <= cmd.angle_second;
      ps <= cmd.angle_third;
    end
    vx[0] <= cmd.vec_x;
    vy[0] <= cmd.vec_y;
    vz[0] <= cmd.vec_z;
    for (int k = 1; k <= VD; k++) begin
      vx[k] <= vx[k-1];
      vy[k] <= vy[k-1];
      vz[k] <= vz[k-1];
    end
  end

  ezr_sincos u_sc_ph (.clk(clk), .angle(ph), .trig(trig_ph));
  ezr_sincos u_sc_th (.clk(clk), .angle(th), .trig(trig_th));
  ezr_sincos u_sc_ps (.clk(clk), .angle(ps), .trig(trig_ps));

  ezr_rotate u_rot (
    .clk    (clk),
    .phi    (trig_ph),
    .theta  (trig_th),
    .psi    (trig_ps),
    .vec_x  (vx[VD]),
    .vec_y  (vy[VD]),
    .vec_z  (vz[VD]),
    .result (result)
  );

endmodule

`default_nettype wire

@@ src/ezr_sincos.sv @@
// Pipelined sine and cosine of one angle, Q16 results, sixteen stages.
`default_nettype none

module ezr_sincos (
  input  wire logic                             clk,
  input  wire logic [ezr_pkg::ANGLE_WIDTH-1:0]  angle,
  output ezr_pkg::trig_t                        trig
);

  localparam int AW = ezr_pkg::ANGLE_WIDTH;

  logic [31:0] u;
  logic [29:0] f;
  logic [29:0] g_next;
  logic        swap_next;

  logic [29:0] g;
  logic [1:0]  q_pipe    [0:14];
  logic        swap_pipe [0:14];
  logic [29:0] t_pipe    [1:11];
  logic [29:0] t2_pipe   [2:11];

  logic [60:0] t_prod;
  logic [59:0] t2_prod;

  logic [29:0] s_v  [0:3];
  logic [29:0] s_ve [0:3];
  logic [29:0] s_qe [0:2];
  logic [30:0] s_p  [0:3];
  logic [29:0] c_v  [0:3];
  logic [29:0] c_ve [0:3];
  logic [29:0] c_qe [0:3];
  logic [30:0] c_p  [0:3];

  logic [30:0] s_fin;
  logic [30:0] c_fin;
  logic [31:0] s_sum;
  logic [31:0] c_sum;
  logic signed [ezr_pkg::TRIG_WIDTH-1:0] sm;
  logic signed [ezr_pkg::TRIG_WIDTH-1:0] cm;

  // Fold the angle into the first octant of its quadrant.
  assign u         = {angle, {(32 - AW){1'b0}}};
  assign f         = u[29:0];
  assign swap_next = f > 30'h2000_0000;
  assign g_next    = swap_next ? 30'(31'h4000_0000 - {1'b0, f}) : f;

  assign t_prod  = 61'(g) * 61'(ezr_pkg::TWO_PI_Q28);
  assign t2_prod = 60'(t_pipe[1]) * 60'(t_pipe[1]);

  always_ff @(posedge clk) begin
    g            <= g_next;
    q_pipe[0]    <= u[31:30];
    swap_pipe[0] <= swap_next;
    for (int k = 1; k < 15; k++) begin
      q_pipe[k]    <= q_pipe[k-1];
      swap_pipe[k] <= swap_pipe[k-1];
    end
    t_pipe[1]  <= t_prod[59:30];
    t2_pipe[2] <= t2_prod[59:30];
    for (int k = 2; k < 12; k++) begin
      t_pipe[k] <= t_pipe[k-1];
    end
    for (int k = 3; k < 12; k++) begin
      t2_pipe[k] <= t2_pipe[k-1];
    end
  end

  // Each series level takes three stages: product, reciprocal estimate, correction.
  for (genvar L = 0; L < 4; L++) begin : g_lvl
    localparam logic [31:0] CM = 32'(64'h1_0000_0000 / ezr_pkg::COS_DIV[L]);

    logic [30:0] s_pin;
    logic [30:0] c_pin;
    logic [60:0] s_mul;
    logic [60:0] c_mul;
    logic [61:0] c_est;
    logic [35:0] c_r;
    logic [29:0] c_q;

    if (L == 0) begin : g_first
      assign s_pin = ezr_pkg::ONE_Q30;
      assign c_pin = ezr_pkg::ONE_Q30;
    end else begin : g_rest
      assign s_pin = s_p[L-1];
      assign c_pin = c_p[L-1];
    end

    assign c_mul = 61'(t2_pipe[2+3*L]) * 61'(c_pin);
    assign c_est = 62'(c_v[L]) * 62'(CM);
    assign c_r   = 36'(c_ve[L]) - 36'(c_qe[L]) * 36'(ezr_pkg::COS_DIV[L]);
    assign c_q   = c_qe[L] + 30'(c_r >= 36'(ezr_pkg::COS_DIV[L]));

    always_ff @(posedge clk) begin
      c_v[L]  <= c_mul[59:30];
      c_ve[L] <= c_v[L];
      c_qe[L] <= c_est[61:32];
      c_p[L]  <= ezr_pkg::ONE_Q30 - 31'(c_q);
    end

    if (L < 3) begin : g_sin_div
      localparam logic [31:0] SM = 32'(64'h1_0000_0000 / ezr_pkg::SIN_DIV[L]);

      logic [61:0] s_est;
      logic [35:0] s_r;
      logic [29:0] s_q;

      assign s_mul = 61'(t2_pipe[2+3*L]) * 61'(s_pin);
      assign s_est = 62'(s_v[L]) * 62'(SM);
      assign s_r   = 36'(s_ve[L]) - 36'(s_qe[L]) * 36'(ezr_pkg::SIN_DIV[L]);
      assign s_q   = s_qe[L] + 30'(s_r >= 36'(ezr_pkg::SIN_DIV[L]));

      always_ff @(posedge clk) begin
        s_v[L]  <= s_mul[59:30];
        s_ve[L] <= s_v[L];
        s_qe[L] <= s_est[61:32];
        s_p[L]  <= ezr_pkg::ONE_Q30 - 31'(s_q);
      end
    end else begin : g_sin_last
      // The sine ends with the product by t; the value then waits for the cosine.
      assign s_mul = 61'(t_pipe[2+3*L]) * 61'(s_pin);

      always_ff @(posedge clk) begin
        s_v[L]  <= s_mul[59:30];
        s_ve[L] <= s_v[L];
        s_p[L]  <= {1'b0, s_ve[L]};
      end
    end
  end

  assign s_fin = swap_pipe[14] ? c_p[3] : s_p[3];
  assign c_fin = swap_pipe[14] ? s_p[3] : c_p[3];
  assign s_sum = 32'(s_fin) + 32'd8192;
  assign c_sum = 32'(c_fin) + 32'd8192;
  assign sm    = ezr_pkg::TRIG_WIDTH'({1'b0, s_sum[30:14]});
  assign cm    = ezr_pkg::TRIG_WIDTH'({1'b0, c_sum[30:14]});

  always_ff @(posedge clk) begin
    case (q_pipe[14])
      2'd0: begin
        trig.sn <= sm;
        trig.cs <= cm;
      end
      2'd1: begin
        trig.sn <= cm;
        trig.cs <= -sm;
      end
      2'd2: begin
        trig.sn <= -sm;
        trig.cs <= -cm;
      end
      default: begin
        trig.sn <= -cm;
        trig.cs <= sm;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/ezr_rotate.sv @@
// Rotation matrix from sines and cosines and its product with the vector, eight stages.
`default_nettype none

module ezr_rotate (
  input  wire logic                                 clk,
  input  wire ezr_pkg::trig_t                       phi,
  input  wire ezr_pkg::trig_t                       theta,
  input  wire ezr_pkg::trig_t                       psi,
  input  wire logic signed [ezr_pkg::COORD_WIDTH-1:0] vec_x,
  input  wire logic signed [ezr_pkg::COORD_WIDTH-1:0] vec_y,
  input  wire logic signed [ezr_pkg::COORD_WIDTH-1:0] vec_z,
  output ezr_pkg::result_t                          result
);

  localparam int CW   = ezr_pkg::COORD_WIDTH;
  localparam int TW   = ezr_pkg::TRIG_WIDTH;
  localparam int EW   = ezr_pkg::ENTRY_WIDTH;
  localparam int WA   = ezr_pkg::A48_WIDTH;
  localparam int PW   = ezr_pkg::PROD_WIDTH;
  localparam int ACCW = ezr_pkg::ACC_WIDTH;

  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

  function automatic logic signed [EW-1:0] round_a48(input logic signed [WA-1:0] v);
    logic [WA-1:0] m;
    m = v[WA-1] ? WA'(-v) : WA'(v);
    m = (m + (WA'(1) << 31)) >> 32;
    return v[WA-1] ? -EW'(m) : EW'(m);
  endfunction

  function automatic logic signed [ACCW-1:0] round_acc(input logic signed [ACCW-1:0] v);
    logic [ACCW-1:0] m;
    m = v[ACCW-1] ? ACCW'(-v) : ACCW'(v);
    m = (m + (ACCW'(1) << 15)) >> 16;
    return v[ACCW-1] ? -ACCW'(m) : ACCW'(m);
  endfunction

  // Pair products: cps*cph, cps*sph, sps*cph, sps*sph, sps*sth, cps*sth, sth*sph, sth*cph.
  logic signed [2*TW-1:0] p0 [0:7];
  logic signed [2*TW-1:0] p1 [0:7];
  logic signed [2*TW-1:0] hs;
  logic signed [2*TW-1:0] hc;
  logic signed [TW-1:0]   cth0;
  logic signed [TW-1:0]   cth1;
  logic signed [TW-1:0]   sps0;
  logic signed [TW-1:0]   cps0;
  logic signed [3*TW-1:0] q_ss;
  logic signed [3*TW-1:0] q_cs;
  logic signed [3*TW-1:0] q_sc;
  logic signed [3*TW-1:0] q_cc;
  logic signed [WA-1:0]   a48 [0:8];
  logic signed [EW-1:0]   ent [0:8];
  logic signed [PW-1:0]   prod [0:8];
  logic signed [ACCW-1:0] acc [0:2];
  logic signed [ACCW-1:0] rnd [0:2];
  logic signed [ACCW-1:0] sat [0:2];
  logic signed [CW-1:0]   x_pipe [0:3][0:2];

  always_ff @(posedge clk) begin
    p0[0] <= psi.cs * phi.cs;
    p0[1] <= psi.cs * phi.sn;
    p0[2] <= psi.sn * phi.cs;
    p0[3] <= psi.sn * phi.sn;
    p0[4] <= psi.sn * theta.sn;
    p0[5] <= psi.cs * theta.sn;
    p0[6] <= theta.sn * phi.sn;
    p0[7] <= theta.sn * phi.cs;
    hs    <= theta.cs * phi.sn;
    hc    <= theta.cs * phi.cs;
    cth0  <= theta.cs;
    sps0  <= psi.sn;
    cps0  <= psi.cs;

    p1   <= p0;
    cth1 <= cth0;
    q_ss <= hs * sps0;
    q_cs <= hc * sps0;
    q_sc <= hs * cps0;
    q_cc <= hc * cps0;

    // Entries in Q48, exact.
    a48[0] <= (WA'(p1[0]) <<< 16) - WA'(q_ss);
    a48[1] <= (WA'(p1[1]) <<< 16) + WA'(q_cs);
    a48[2] <= WA'(p1[4]) <<< 16;
    a48[3] <= -(WA'(p1[2]) <<< 16) - WA'(q_sc);
    a48[4] <= -(WA'(p1[3]) <<< 16) + WA'(q_cc);
    a48[5] <= WA'(p1[5]) <<< 16;
    a48[6] <= WA'(p1[6]) <<< 16;
    a48[7] <= -(WA'(p1[7]) <<< 16);
    a48[8] <= WA'(cth1) <<< 32;

    for (int k = 0; k < 9; k++) begin
      ent[k] <= round_a48(a48[k]);
    end

    x_pipe[0][0] <= vec_x;
    x_pipe[0][1] <= vec_y;
    x_pipe[0][2] <= vec_z;
    for (int k = 1; k < 4; k++) begin
      x_pipe[k] <= x_pipe[k-1];
    end

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[3*i+j] <= PW'(ent[3*i+j]) * PW'(x_pipe[3][j]);
      end
    end

    for (int i = 0; i < 3; i++) begin
      acc[i] <= ACCW'(prod[3*i]) + ACCW'(prod[3*i+1]) + ACCW'(prod[3*i+2]);
      rnd[i] <= round_acc(acc[i]);
    end

    result.rot_x <= CW'(sat[0]);
    result.rot_y <= CW'(sat[1]);
    result.rot_z <= CW'(sat[2]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (rnd[i] > SAT_HI) begin
        sat[i] = SAT_HI;
      end else if (rnd[i] < SAT_LO) begin
        sat[i] = SAT_LO;
      end else begin
        sat[i] = rnd[i];
      end
    end
  end

endmodule

`default_nettype wire
